[rtl/fbsg_pkg.sv]
package fbsg_pkg;

  // Cluster count limits for volume classification
  localparam logic [31:0] ClustersFat12Limit = 32'd4085;
  localparam logic [31:0] ClustersFat16Limit = 32'd65525;
  // Bytes in one directory entry, as a shift
  localparam int unsigned DirEntryShift = 5;

  typedef enum logic [3:0] {
    ERR_NONE,
    ERR_SIGNATURE,
    ERR_CLUSTER_SIZE,
    ERR_SECTOR_SIZE,
    ERR_FAT_COUNT,
    ERR_RESERVED,
    ERR_METADATA,
    ERR_FAT_ZERO,
    ERR_ROOT,
    ERR_OVERFLOW
  } err_e;

  typedef enum logic [1:0] {
    KIND_FAT12,
    KIND_FAT16,
    KIND_FAT32
  } kind_e;

  typedef struct packed {
    logic        signature_found;
    logic [15:0] sector_bytes;
    logic [7:0]  cluster_sectors;
    logic [15:0] reserved_count;
    logic [7:0]  fat_copies;
    logic [15:0] root_entry_count;
    logic [15:0] total_small;
    logic [31:0] total_large;
    logic [15:0] fat_size_small;
    logic [31:0] fat_size_large;
    logic [31:0] hidden_count;
    logic [31:0] root_first_cluster;
  } bpb_t;

  typedef struct packed {
    logic        geometry_ok;
    err_e        error_cause;
    kind_e       fat_kind;
    logic [31:0] cluster_total;
    logic [31:0] fat_length;
    logic [15:0] fat_start_sector;
    logic [31:0] root_start_sector;
    logic [12:0] root_size_sectors;
    logic [31:0] data_start_sector;
    logic [31:0] root_cluster_out;
    logic [31:0] hidden_out;
  } geom_t;

endpackage

[rtl/fat_boot_sector_geometry_check.sv]
// A result beat passes through the input register, then the result register.
// Throughput: one beat per cycle; the input side stalls only when both
// stages are full and the output is stalled.
// Reset: rst_ni clears both stage valid flags; payload registers are not reset.
module fat_boot_sector_geometry_check import fbsg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        signature_found_i,
  input  logic [15:0] sector_bytes_i,
  input  logic [7:0]  cluster_sectors_i,
  input  logic [15:0] reserved_count_i,
  input  logic [7:0]  fat_copies_i,
  input  logic [15:0] root_entry_count_i,
  input  logic [15:0] total_small_i,
  input  logic [31:0] total_large_i,
  input  logic [15:0] fat_size_small_i,
  input  logic [31:0] fat_size_large_i,
  input  logic [31:0] hidden_count_i,
  input  logic [31:0] root_first_cluster_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        geometry_ok_o,
  output logic [3:0]  error_cause_o,
  output logic [1:0]  fat_kind_o,
  output logic [31:0] cluster_total_o,
  output logic [31:0] fat_length_o,
  output logic [15:0] fat_start_sector_o,
  output logic [31:0] root_start_sector_o,
  output logic [12:0] root_size_sectors_o,
  output logic [31:0] data_start_sector_o,
  output logic [31:0] root_cluster_out_o,
  output logic [31:0] hidden_out_o
);

  // Stage 1: input register holding the raw boot-sector fields
  logic  in_vld_q;
  bpb_t  bpb_q;
  bpb_t  bpb_d;
  // Stage 2: result register
  logic  res_vld_q;
  geom_t res_q;
  geom_t res_d;

  logic  res_load;  // result register may take a new beat
  logic  in_load;   // input register may take a new beat

  // The result stage frees up whenever it is empty or its beat is taken.
  assign res_load   = !res_vld_q || !out_stall_i;
  // The input stage moves on whenever its content can drop into the result stage.
  assign in_load    = !in_vld_q || res_load;
  assign in_stall_o = !in_load;

  assign bpb_d = '{
    signature_found:    signature_found_i,
    sector_bytes:       sector_bytes_i,
    cluster_sectors:    cluster_sectors_i,
    reserved_count:     reserved_count_i,
    fat_copies:         fat_copies_i,
    root_entry_count:   root_entry_count_i,
    total_small:        total_small_i,
    total_large:        total_large_i,
    fat_size_small:     fat_size_small_i,
    fat_size_large:     fat_size_large_i,
    hidden_count:       hidden_count_i,
    root_first_cluster: root_first_cluster_i
  };

  // All checks, geometry and classification in one combinational pass
  fbsg_calc u_calc (
    .bpb_i  (bpb_q),
    .geom_o (res_d)
  );

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_load)  in_vld_q  <= in_valid_i;
      if (res_load) res_vld_q <= in_vld_q;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) bpb_q <= bpb_d;
    if (res_load && in_vld_q)  res_q <= res_d;
  end

  assign out_valid_o         = res_vld_q;
  assign geometry_ok_o       = res_q.geometry_ok;
  assign error_cause_o       = res_q.error_cause;
  assign fat_kind_o          = res_q.fat_kind;
  assign cluster_total_o     = res_q.cluster_total;
  assign fat_length_o        = res_q.fat_length;
  assign fat_start_sector_o  = res_q.fat_start_sector;
  assign root_start_sector_o = res_q.root_start_sector;
  assign root_size_sectors_o = res_q.root_size_sectors;
  assign data_start_sector_o = res_q.data_start_sector;
  assign root_cluster_out_o  = res_q.root_cluster_out;
  assign hidden_out_o        = res_q.hidden_out;

endmodule

[rtl/fbsg_calc.sv]
module fbsg_calc import fbsg_pkg::*; (
  input  bpb_t  bpb_i,
  output geom_t geom_o
);

  logic        spc_ok;
  logic        bps_ok;
  logic        nfat_ok;
  logic [2:0]  spc_log;
  logic [21:0] root_sum;
  logic [12:0] root_secs;
  logic [31:0] total;
  logic [31:0] fat_any;
  logic [35:0] meta;
  logic [31:0] free_secs;
  logic [31:0] clusters;
  kind_e       kind;
  logic [31:0] fat_len;
  logic [34:0] fat_end;
  logic [35:0] data_start;
  err_e        err;

  assign spc_ok  = (bpb_i.cluster_sectors != 8'd0) &&
                   ((bpb_i.cluster_sectors & (bpb_i.cluster_sectors - 8'd1)) == 8'd0);
  assign bps_ok  = (bpb_i.sector_bytes == 16'd512)  || (bpb_i.sector_bytes == 16'd1024) ||
                   (bpb_i.sector_bytes == 16'd2048) || (bpb_i.sector_bytes == 16'd4096);
  assign nfat_ok = (bpb_i.fat_copies != 8'd0) && (bpb_i.fat_copies <= 8'd4);

  // one-hot to index; only meaningful once spc_ok holds
  always_comb begin
    spc_log = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (bpb_i.cluster_sectors[i]) spc_log = 3'(i);
    end
  end

  // root dir sectors: ceil(entries * 32 / bps), bps a power of two
  assign root_sum = (22'(bpb_i.root_entry_count) << DirEntryShift) +
                    22'(bpb_i.sector_bytes - 16'd1);
  always_comb begin
    case (bpb_i.sector_bytes)
      16'd512:  root_secs = root_sum[21:9];
      16'd1024: root_secs = 13'(root_sum[21:10]);
      16'd2048: root_secs = 13'(root_sum[21:11]);
      16'd4096: root_secs = 13'(root_sum[21:12]);
      default:  root_secs = 13'd0;
    endcase
  end

  assign total   = (bpb_i.total_small != 16'd0) ? 32'(bpb_i.total_small) : bpb_i.total_large;
  assign fat_any = (bpb_i.fat_size_small != 16'd0) ? 32'(bpb_i.fat_size_small)
                                                   : bpb_i.fat_size_large;
  assign meta    = 36'(bpb_i.reserved_count) +
                   (36'(fat_any) * 36'(bpb_i.fat_copies[2:0])) +
                   36'(root_secs);

  assign free_secs = total - meta[31:0];
  assign clusters  = free_secs >> spc_log;

  always_comb begin
    if (clusters < ClustersFat12Limit) begin
      kind = KIND_FAT12;
    end else if (clusters < ClustersFat16Limit) begin
      kind = KIND_FAT16;
    end else begin
      kind = KIND_FAT32;
    end
  end

  assign fat_len    = (kind == KIND_FAT32) ? bpb_i.fat_size_large : 32'(bpb_i.fat_size_small);
  assign fat_end    = 35'(bpb_i.reserved_count) + (35'(fat_len) * 35'(bpb_i.fat_copies[2:0]));
  assign data_start = (kind == KIND_FAT32) ? 36'(fat_end)
                                           : 36'(fat_end) + 36'(root_secs);

  // first failing check wins
  always_comb begin
    if (!bpb_i.signature_found) begin
      err = ERR_SIGNATURE;
    end else if (!spc_ok) begin
      err = ERR_CLUSTER_SIZE;
    end else if (!bps_ok) begin
      err = ERR_SECTOR_SIZE;
    end else if (!nfat_ok) begin
      err = ERR_FAT_COUNT;
    end else if (bpb_i.reserved_count == 16'd0) begin
      err = ERR_RESERVED;
    end else if (meta >= 36'(total)) begin
      err = ERR_METADATA;
    end else if (fat_len == 32'd0) begin
      err = ERR_FAT_ZERO;
    end else if ((kind != KIND_FAT32) && (bpb_i.root_entry_count == 16'd0)) begin
      err = ERR_ROOT;
    end else if (data_start[35:32] != 4'd0) begin
      err = ERR_OVERFLOW;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    geom_o = '0;
    if (err == ERR_NONE) begin
      geom_o.geometry_ok       = 1'b1;
      geom_o.fat_kind          = kind;
      geom_o.cluster_total     = clusters;
      geom_o.fat_length        = fat_len;
      geom_o.fat_start_sector  = bpb_i.reserved_count;
      geom_o.root_start_sector = fat_end[31:0];
      geom_o.root_size_sectors = root_secs;
      geom_o.data_start_sector = data_start[31:0];
      geom_o.root_cluster_out  = bpb_i.root_first_cluster;
      geom_o.hidden_out        = bpb_i.hidden_count;
    end
    geom_o.error_cause = err;
  end

endmodule

[tb/fat_boot_sector_geometry_check_tb.sv]
`timescale 1ns / 100ps

module fat_boot_sector_geometry_check_tb import fbsg_pkg::*; ();

  // Cycles without any beat on either side before the run is called hung.
  // The longest idle is the longest gap or stall drawn from idle_length().
  localparam int unsigned StuckLimit  = 4000;
  localparam int unsigned RandomBeats = 1426;
  // Slack after the last result beat is taken, before the verdict is given.
  localparam int unsigned DrainCycles = 8;

  logic        clk_i                = 1'b0;
  logic        rst_ni               = 1'b0;
  logic        in_valid_i           = 1'b0;
  logic        in_stall_o;
  logic        signature_found_i    = 1'b0;
  logic [15:0] sector_bytes_i       = '0;
  logic [7:0]  cluster_sectors_i    = '0;
  logic [15:0] reserved_count_i     = '0;
  logic [7:0]  fat_copies_i         = '0;
  logic [15:0] root_entry_count_i   = '0;
  logic [15:0] total_small_i        = '0;
  logic [31:0] total_large_i        = '0;
  logic [15:0] fat_size_small_i     = '0;
  logic [31:0] fat_size_large_i     = '0;
  logic [31:0] hidden_count_i       = '0;
  logic [31:0] root_first_cluster_i = '0;
  logic        out_valid_o;
  logic        out_stall_i          = 1'b0;
  logic        geometry_ok_o;
  logic [3:0]  error_cause_o;
  logic [1:0]  fat_kind_o;
  logic [31:0] cluster_total_o;
  logic [31:0] fat_length_o;
  logic [15:0] fat_start_sector_o;
  logic [31:0] root_start_sector_o;
  logic [12:0] root_size_sectors_o;
  logic [31:0] data_start_sector_o;
  logic [31:0] root_cluster_out_o;
  logic [31:0] hidden_out_o;

  fat_boot_sector_geometry_check dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // One row of the directed table: either the result is written out by hand
  // (rejections, where everything but the cause is zero) or it is predicted.
  typedef struct {
    bpb_t  stim;
    bit    typed;
    geom_t want;
  } row_t;

  row_t        plan[$];
  geom_t       expected_geom_q[$];
  geom_t       want;
  int unsigned mismatches   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_cycles  = 0;
  // When set, neither side idles: back-to-back beats and no stalls.
  bit          quiet        = 1'b0;

  function automatic geom_t refused(err_e cause);
    geom_t g;
    g = '0;
    g.error_cause = cause;
    return g;
  endfunction

  // Root directory size in sectors, rounded up.
  function automatic logic [63:0] root_dir_sectors(logic [15:0] entries, logic [15:0] bps);
    return ((64'(entries) << DirEntryShift) + 64'(bps) - 64'd1) / 64'(bps);
  endfunction

  // Geometry predicted from one boot-sector beat; checks are taken in order
  // of the cause codes and the first failing one wins.
  function automatic geom_t geometry_of(bpb_t b);
    geom_t       g;
    kind_e       kind;
    logic [63:0] root_secs, total, fat_any, meta, clusters, fat_len;
    logic [63:0] fat_end, data_start;
    if (!b.signature_found) return refused(ERR_SIGNATURE);
    if (b.cluster_sectors == 8'd0 || b.cluster_sectors > 8'd128 ||
        (b.cluster_sectors & (b.cluster_sectors - 8'd1)) != 8'd0)
      return refused(ERR_CLUSTER_SIZE);
    if (b.sector_bytes != 16'd512 && b.sector_bytes != 16'd1024 &&
        b.sector_bytes != 16'd2048 && b.sector_bytes != 16'd4096)
      return refused(ERR_SECTOR_SIZE);
    if (b.fat_copies == 8'd0 || b.fat_copies > 8'd4) return refused(ERR_FAT_COUNT);
    if (b.reserved_count == 16'd0) return refused(ERR_RESERVED);

    root_secs = root_dir_sectors(b.root_entry_count, b.sector_bytes);
    total     = (b.total_small != 16'd0) ? 64'(b.total_small) : 64'(b.total_large);
    // metadata is sized with whichever FAT size field is populated
    fat_any   = (b.fat_size_small != 16'd0) ? 64'(b.fat_size_small) : 64'(b.fat_size_large);
    meta      = 64'(b.reserved_count) + 64'(b.fat_copies) * fat_any + root_secs;
    if (meta >= total) return refused(ERR_METADATA);

    clusters = (total - meta) / 64'(b.cluster_sectors);
    if (clusters < 64'(ClustersFat12Limit))      kind = KIND_FAT12;
    else if (clusters < 64'(ClustersFat16Limit)) kind = KIND_FAT16;
    else                                         kind = KIND_FAT32;

    // but the FAT length itself comes from the field the type owns
    fat_len = (kind == KIND_FAT32) ? 64'(b.fat_size_large) : 64'(b.fat_size_small);
    if (fat_len == 64'd0) return refused(ERR_FAT_ZERO);
    if (kind != KIND_FAT32 && b.root_entry_count == 16'd0) return refused(ERR_ROOT);

    fat_end = 64'(b.reserved_count) + 64'(b.fat_copies) * fat_len;
    if (fat_end > 64'hFFFF_FFFF) return refused(ERR_OVERFLOW);
    // FAT32 keeps its root in the cluster area, so no fixed root region
    data_start = (kind == KIND_FAT32) ? fat_end : fat_end + root_secs;
    if (data_start > 64'hFFFF_FFFF) return refused(ERR_OVERFLOW);

    g.geometry_ok       = 1'b1;
    g.error_cause       = ERR_NONE;
    g.fat_kind          = kind;
    g.cluster_total     = clusters[31:0];
    g.fat_length        = fat_len[31:0];
    g.fat_start_sector  = b.reserved_count;
    g.root_start_sector = fat_end[31:0];
    g.root_size_sectors = root_secs[12:0];
    g.data_start_sector = data_start[31:0];
    g.root_cluster_out  = b.root_first_cluster;
    g.hidden_out        = b.hidden_count;
    return g;
  endfunction

  function automatic bpb_t mk(logic sig, logic [15:0] bps, logic [7:0] spc,
                              logic [15:0] rsv, logic [7:0] nfat, logic [15:0] rent,
                              logic [15:0] tsmall, logic [31:0] tlarge,
                              logic [15:0] fsmall, logic [31:0] flarge,
                              logic [31:0] hidden, logic [31:0] rclus);
    bpb_t b;
    b.signature_found    = sig;
    b.sector_bytes       = bps;
    b.cluster_sectors    = spc;
    b.reserved_count     = rsv;
    b.fat_copies         = nfat;
    b.root_entry_count   = rent;
    b.total_small        = tsmall;
    b.total_large        = tlarge;
    b.fat_size_small     = fsmall;
    b.fat_size_large     = flarge;
    b.hidden_count       = hidden;
    b.root_first_cluster = rclus;
    return b;
  endfunction

  // Mostly short gaps, the odd long one.
  function automatic int unsigned idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A plausible volume aimed at one FAT type: the total is built back from
  // a chosen cluster count, so all three types and their borders are hit.
  function automatic bpb_t well_formed_bpb();
    bpb_t        b;
    int unsigned target, pick;
    logic [63:0] fat_any, meta, clusters, total;
    b.signature_found    = 1'b1;
    b.cluster_sectors    = 8'd1 << $urandom_range(0, 7);
    b.sector_bytes       = 16'd512 << $urandom_range(0, 3);
    b.fat_copies         = 8'($urandom_range(1, 4));
    b.reserved_count     = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 65535))
                                                       : 16'($urandom_range(1, 64));
    b.hidden_count       = $urandom;
    b.root_first_cluster = $urandom;
    b.fat_size_large     = $urandom;
    target = $urandom_range(0, 2);
    pick   = $urandom_range(0, 7);
    if (target != 2) begin
      b.root_entry_count = (pick == 0) ? 16'($urandom) : 16'($urandom_range(1, 1024));
      b.fat_size_small   = (pick == 1) ? 16'd0 : 16'($urandom_range(1, 512));
      if (target == 0) begin
        clusters = (pick == 2) ? 64'd4084 : 64'($urandom_range(1, 4084));
      end else begin
        clusters = (pick == 2) ? 64'd4085 : (pick == 3) ? 64'd65524
                                          : 64'($urandom_range(4085, 65524));
      end
    end else begin
      b.root_entry_count = (pick < 2) ? 16'($urandom) : 16'd0;
      // a stray small FAT size makes the metadata and the type disagree
      b.fat_size_small   = (pick == 2) ? 16'($urandom_range(1, 65535)) : 16'd0;
      if (pick != 3) b.fat_size_large = $urandom_range(1, 1 << 20);
      clusters = (pick == 4) ? 64'd65525 : 64'($urandom_range(65525, 1 << 24));
    end
    fat_any = (b.fat_size_small != 16'd0) ? 64'(b.fat_size_small) : 64'(b.fat_size_large);
    meta    = 64'(b.reserved_count) + 64'(b.fat_copies) * fat_any +
              root_dir_sectors(b.root_entry_count, b.sector_bytes);
    total   = meta + clusters * 64'(b.cluster_sectors) +
              64'($urandom_range(0, b.cluster_sectors - 1));
    b.total_large = $urandom;
    if (total < 64'd65536 && $urandom_range(0, 1) == 1) begin
      b.total_small = total[15:0];
    end else begin
      b.total_small = 16'd0;
      b.total_large = total[31:0];
    end
    return b;
  endfunction

  // Spoil one field of an otherwise sound volume.
  function automatic bpb_t corrupt_bpb(bpb_t b);
    case ($urandom_range(0, 5))
      0: b.signature_found = 1'b0;
      1: b.cluster_sectors = 8'($urandom);
      2: b.sector_bytes    = 16'($urandom);
      3: b.fat_copies      = 8'($urandom);
      4: b.reserved_count  = 16'd0;
      default: begin
        b.total_small = 16'd0;
        b.total_large = $urandom_range(0, 200);
      end
    endcase
    return b;
  endfunction

  function automatic bpb_t noise_bpb();
    return mk(1'($urandom), 16'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), $urandom, 16'($urandom), $urandom,
              $urandom, $urandom);
  endfunction

  // Present one beat and hold it until taken. Valid only drops when a gap
  // follows, so it is never lowered and raised within the same step.
  task automatic send_beat(bpb_t b, geom_t expected);
    int unsigned gap;
    gap = idle_length();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    signature_found_i    <= b.signature_found;
    sector_bytes_i       <= b.sector_bytes;
    cluster_sectors_i    <= b.cluster_sectors;
    reserved_count_i     <= b.reserved_count;
    fat_copies_i         <= b.fat_copies;
    root_entry_count_i   <= b.root_entry_count;
    total_small_i        <= b.total_small;
    total_large_i        <= b.total_large;
    fat_size_small_i     <= b.fat_size_small;
    fat_size_large_i     <= b.fat_size_large;
    hidden_count_i       <= b.hidden_count;
    root_first_cluster_i <= b.root_first_cluster;
    expected_geom_q.push_back(expected);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic check_field(string field, logic [31:0] expected, logic [31:0] got);
    if (got !== expected) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %h, got %h", $time, field, expected, got);
    end
  endtask

  // Result side: random stall, held for a while, then released for a while.
  always @(posedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles--;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      hold_cycles = quiet ? 0 : $urandom_range(0, 15);
    end else if (idle_length() != 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = idle_length();
    end
  end

  // Every result beat is matched against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_geom_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result beat with nothing outstanding", $time);
      end else begin
        want = expected_geom_q.pop_front();
        check_field("geometry_ok", want.geometry_ok, geometry_ok_o);
        check_field("error_cause", want.error_cause, error_cause_o);
        check_field("fat_kind", want.fat_kind, fat_kind_o);
        check_field("cluster_total", want.cluster_total, cluster_total_o);
        check_field("fat_length", want.fat_length, fat_length_o);
        check_field("fat_start_sector", want.fat_start_sector, fat_start_sector_o);
        check_field("root_start_sector", want.root_start_sector, root_start_sector_o);
        check_field("root_size_sectors", want.root_size_sectors, root_size_sectors_o);
        check_field("data_start_sector", want.data_start_sector, data_start_sector_o);
        check_field("root_cluster_out", want.root_cluster_out, root_cluster_out_o);
        check_field("hidden_out", want.hidden_out, hidden_out_o);
      end
    end
  end

  // Hang detector: any beat on either side resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    bpb_t b;
    int unsigned r;

    // Rejections in check order; passed-through fields are all ones on the
    // first row to show they are zeroed.
    plan.push_back('{mk(0, 512, 1, 1, 2, 512, 4141, 0, 12, 0, '1, '1), 1,
                     refused(ERR_SIGNATURE)});
    plan.push_back('{mk(1, 512, 0, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_CLUSTER_SIZE)});
    plan.push_back('{mk(1, 512, 255, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_CLUSTER_SIZE)});
    plan.push_back('{mk(1, 512, 3, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_CLUSTER_SIZE)});
    plan.push_back('{mk(1, 0, 128, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_SECTOR_SIZE)});
    plan.push_back('{mk(1, 16'hFFFF, 1, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_SECTOR_SIZE)});
    plan.push_back('{mk(1, 256, 1, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_SECTOR_SIZE)});
    plan.push_back('{mk(1, 8192, 1, 1, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_SECTOR_SIZE)});
    plan.push_back('{mk(1, 512, 1, 1, 0, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_FAT_COUNT)});
    plan.push_back('{mk(1, 512, 1, 1, 5, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_FAT_COUNT)});
    plan.push_back('{mk(1, 512, 1, 1, 255, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_FAT_COUNT)});
    plan.push_back('{mk(1, 512, 1, 0, 2, 512, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_RESERVED)});
    // empty volume, then metadata exactly filling it (1 + 2*12 + 32 = 57)
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 0, 0, 12, 0, 0, 0), 1,
                     refused(ERR_METADATA)});
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 57, 0, 12, 0, 0, 0), 1,
                     refused(ERR_METADATA)});
    // FAT12 sized from the large field, but FAT12 reads the small one
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 4141, 0, 0, 12, 0, 0), 1,
                     refused(ERR_FAT_ZERO)});
    // no root entries on a FAT16
    plan.push_back('{mk(1, 512, 1, 1, 2, 0, 4141, 0, 12, 0, 0, 0), 1,
                     refused(ERR_ROOT)});
    // FAT32 with a stray small size: huge large size overflows the root start
    plan.push_back('{mk(1, 512, 1, 32, 2, 0, 0, '1, 1, '1, 0, 0), 1,
                     refused(ERR_OVERFLOW)});
    plan.push_back('{mk(1, 512, 1, 32, 2, 0, 0, '1, 1, 0, 0, 0), 1,
                     refused(ERR_FAT_ZERO)});
    // Type borders: 4084 / 4085 / 65524 / 65525 clusters
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 4141, 0, 12, 0, 32'h1234, 2), 0, '0});
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 4142, 0, 12, 0, 0, 3), 0, '0});
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 0, 66069, 256, 0, 7, 0), 0, '0});
    plan.push_back('{mk(1, 512, 1, 1, 2, 512, 0, 66070, 256, 600, 0, 2), 0, '0});
    // Extremes: largest root (4096 sectors), full 32-bit total, max spc
    plan.push_back('{mk(1, 512, 128, 16'hFFFF, 4, 16'hFFFF, 0, '1, 0, 32'h0010_0000,
                        '1, '1), 0, '0});
    plan.push_back('{mk(1, 2048, 16, 16'hFFFF, 1, 16'hFFFF, 0, 32'h0010_0000,
                        16'hFFFF, 0, 0, 0), 0, '0});

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i])
      send_beat(plan[i].stim, plan[i].typed ? plan[i].want : geometry_of(plan[i].stim));

    // Random part: mostly sound volumes, some spoilt ones, some raw noise.
    for (int n = 0; n < RandomBeats; n++) begin
      if (n % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70)      b = well_formed_bpb();
      else if (r < 80) b = corrupt_bpb(well_formed_bpb());
      else             b = noise_bpb();
      send_beat(b, geometry_of(b));
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    while (expected_geom_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
